FILE: rtl/positional_array_list_assert.svh
// Assertion macros shared by the positional array list RTL.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pal_pkg.sv
// Package with sizes, codes and control types of the positional array list.
package pal_pkg;

  localparam int DEPTH  = 32;
  localparam int WIDTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int FIDX_W = 5;
  localparam int LEN_W  = 6;
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load_req;
    logic apply;
    logic scan_step;
    logic scan_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_locate;
    logic scan_done;
  } dp_status_t;

endpackage

FILE: rtl/pal_channels.sv
// Request and response channel interfaces of the positional array list.
interface pal_req_if;
  logic                          valid;
  logic                          ready;
  logic [pal_pkg::OP_W-1:0]      operation;
  logic [pal_pkg::POS_W-1:0]     position;
  logic signed [pal_pkg::VAL_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface pal_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [pal_pkg::VAL_W-1:0]  read_value;
  logic [pal_pkg::FIDX_W-1:0]        found_index;
  logic [pal_pkg::LEN_W-1:0]         list_length;

  modport source (output valid, output ok, output read_value, output found_index,
                  output list_length, input ready);
  modport sink   (input valid, input ok, input read_value, input found_index,
                  input list_length, output ready);
endinterface

FILE: rtl/pal_datapath.sv
// Datapath: entry store, count, request registers, scan index and response registers.
`include "positional_array_list_assert.svh"

module pal_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pal_pkg::ctl_cmd_t                 cmd,
  output pal_pkg::dp_status_t               status,
  input  logic [pal_pkg::OP_W-1:0]          in_operation,
  input  logic [pal_pkg::POS_W-1:0]         in_position,
  input  logic signed [pal_pkg::VAL_W-1:0]  in_value,
  output logic                              out_ok,
  output logic signed [pal_pkg::VAL_W-1:0]  out_read_value,
  output logic [pal_pkg::FIDX_W-1:0]        out_found_index,
  output logic [pal_pkg::LEN_W-1:0]         out_list_length
);

  logic [pal_pkg::WIDTH-1:0] entries_r   [pal_pkg::DEPTH];
  logic [pal_pkg::WIDTH-1:0] entries_nxt [pal_pkg::DEPTH];
  logic [pal_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [pal_pkg::OP_W-1:0]  op_r;
  logic [pal_pkg::POS_W-1:0] pos_r;
  logic [pal_pkg::WIDTH-1:0] val_r;
  logic [pal_pkg::CNT_W-1:0] k_r, k_nxt;

  logic                              ok_r, ok_nxt;
  logic [pal_pkg::VAL_W-1:0]         rdval_r, rdval_nxt;
  logic [pal_pkg::FIDX_W-1:0]        fidx_r, fidx_nxt;
  logic [pal_pkg::LEN_W-1:0]         len_r, len_nxt;

  logic [pal_pkg::CMP_W-1:0] pos_w, cnt_w;
  logic                      ins_ok, acc_ok, hit, is_locate;
  logic [pal_pkg::IDX_W-1:0] slot, rd_addr;
  logic [pal_pkg::WIDTH-1:0] rd_word;

  assign pos_w     = pal_pkg::CMP_W'(pos_r);
  assign cnt_w     = pal_pkg::CMP_W'(count_r);
  assign ins_ok    = (cnt_w < pal_pkg::CMP_W'(pal_pkg::DEPTH)) && (pos_w != '0) &&
                     (pos_w <= cnt_w + pal_pkg::CMP_W'(1));
  assign acc_ok    = (pos_w != '0) && (pos_w <= cnt_w);
  assign slot      = pal_pkg::IDX_W'(pos_w - pal_pkg::CMP_W'(1));
  assign is_locate = (op_r == pal_pkg::OP_LOCATE);

  // One read port: the scan index during locate, the addressed slot otherwise.
  assign rd_addr = is_locate ? k_r[pal_pkg::IDX_W-1:0] : slot;
  assign rd_word = entries_r[rd_addr];
  assign hit     = (k_r < count_r) && (rd_word == val_r);

  assign status.is_locate = is_locate;
  assign status.scan_done = hit || (k_r >= count_r);

  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    ok_nxt      = ok_r;
    rdval_nxt   = rdval_r;
    fidx_nxt    = fidx_r;
    len_nxt     = len_r;
    if (cmd.load_req) begin
      k_nxt = '0;
    end else if (cmd.scan_step) begin
      k_nxt = k_r + pal_pkg::CNT_W'(1);
    end
    if (cmd.apply) begin
      ok_nxt    = 1'b0;
      rdval_nxt = '0;
      fidx_nxt  = '0;
      case (op_r)
        pal_pkg::OP_INSERT: begin
          if (ins_ok) begin
            for (int k = 1; k < pal_pkg::DEPTH; k++) begin
              if (pal_pkg::CMP_W'(k) >= pos_w) begin
                entries_nxt[k] = entries_r[k-1];
              end
            end
            entries_nxt[slot] = val_r;
            count_nxt = count_r + pal_pkg::CNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        pal_pkg::OP_DELETE: begin
          if (acc_ok) begin
            for (int k = 0; k < pal_pkg::DEPTH - 1; k++) begin
              if (pal_pkg::CMP_W'(k + 1) >= pos_w) begin
                entries_nxt[k] = entries_r[k+1];
              end
            end
            rdval_nxt = pal_pkg::VAL_W'(rd_word);
            count_nxt = count_r - pal_pkg::CNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        pal_pkg::OP_GET: begin
          if (acc_ok) begin
            rdval_nxt = pal_pkg::VAL_W'(rd_word);
            ok_nxt    = 1'b1;
          end
        end
        pal_pkg::OP_CLEAR: begin
          count_nxt = '0;
          ok_nxt    = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
      len_nxt = pal_pkg::LEN_W'(count_nxt);
    end
    if (cmd.scan_load) begin
      ok_nxt    = hit;
      rdval_nxt = '0;
      fidx_nxt  = hit ? pal_pkg::FIDX_W'(k_r) : '0;
      len_nxt   = pal_pkg::LEN_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entries_r <= entries_nxt;
    k_r       <= k_nxt;
    ok_r      <= ok_nxt;
    rdval_r   <= rdval_nxt;
    fidx_r    <= fidx_nxt;
    len_r     <= len_nxt;
    if (cmd.load_req) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= pal_pkg::WIDTH'(in_value);
    end
  end

  assign out_ok          = ok_r;
  assign out_read_value  = rdval_r;
  assign out_found_index = fidx_r;
  assign out_list_length = len_r;

  `PAL_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= pal_pkg::CNT_W'(pal_pkg::DEPTH), "list count exceeds depth")
  `PAL_ASSERT_IMP(a_scan_in_range, clk, rst_n, cmd.scan_step, k_r < count_r, "scan stepped past the list end")
  `PAL_ASSERT_NXT(a_insert_grows, clk, rst_n, cmd.apply && (op_r == pal_pkg::OP_INSERT) && ins_ok, count_r == $past(count_r) + pal_pkg::CNT_W'(1), "insert did not grow the list")

endmodule

FILE: rtl/pal_controller.sv
// Controller state machine sequencing accept, execute, scan and response load.
`include "positional_array_list_assert.svh"

module pal_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pal_pkg::dp_status_t  status,
  output pal_pkg::ctl_cmd_t    cmd
);

  pal_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            can_load;

  assign can_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pal_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      pal_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = pal_pkg::ST_EXEC;
        end
      end
      pal_pkg::ST_EXEC: begin
        if (status.is_locate) begin
          state_nxt = pal_pkg::ST_SCAN;
        end else if (can_load) begin
          cmd.apply = 1'b1;
          state_nxt = pal_pkg::ST_IDLE;
        end
      end
      pal_pkg::ST_SCAN: begin
        if (!status.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (can_load) begin
          cmd.scan_load = 1'b1;
          state_nxt     = pal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pal_pkg::ST_IDLE;
      end
    endcase
    if (cmd.apply || cmd.scan_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `PAL_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.apply || cmd.scan_load, !out_valid_r || out_ready, "response overwritten before it was taken")
  `PAL_ASSERT_NXT(a_accept_to_exec, clk, rst_n, in_valid && in_ready, state_r == pal_pkg::ST_EXEC, "accepted request not executed next")

endmodule

FILE: rtl/positional_array_list.sv
// A request is accepted in IDLE and applied in EXEC once the output register is free.
// Locate scans one entry per cycle from index 0 until a match or the list end, then waits for that register.
// Requests are handled one at a time: the next is accepted only after the FSM is back in IDLE.
// A new request is taken while the previous response still waits in the output register.
// Reset (rst_n, synchronous, active low) empties the list, idles the controller and
// drops the response valid; entry contents are left as they are until written.
module positional_array_list (
  input  logic     clk,
  input  logic     rst_n,
  pal_req_if.sink  in_req,
  pal_rsp_if.source out_rsp
);

  // Commands flow from the controller to the datapath, status flows back.
  pal_pkg::ctl_cmd_t   cmd;
  pal_pkg::dp_status_t status;

  // The controller owns both handshakes. It takes a request only in its idle
  // state, passes through its execute state, and for locate walks the list one
  // entry per cycle. A finished response is loaded into the output register only
  // when that register is empty or being drained in the same cycle.
  pal_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the entry store as registers so that insert and delete
  // shift every entry together when applied. The stored request, the scan index,
  // the list length and the response payload registers also live here.
  pal_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_operation    (in_req.operation),
    .in_position     (in_req.position),
    .in_value        (in_req.value),
    .out_ok          (out_rsp.ok),
    .out_read_value  (out_rsp.read_value),
    .out_found_index (out_rsp.found_index),
    .out_list_length (out_rsp.list_length)
  );

endmodule
